// ===== hw/rtl/gb2d_pkg.sv =====
// Package for the 2x2 grid binning block.
// Holds default parameter values, register indexes and configuration widths.
// No dependencies.
package gb2d_pkg;

    localparam int MAX_COLS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ROWS_W   = 13;
    localparam int COLS_W   = 11;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    localparam int ROWS_LIMIT = 4096;
    localparam int ROWS_RESET = 512;
    localparam int COLS_RESET = 512;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

endpackage

// ===== hw/rtl/gb2d_line_store.sv =====
// Line store for the horizontal pair sums of the last even row.
// One write port and one read port with registered read data.
// No package dependencies.
module gb2d_line_store #(
    parameter int DEPTH  = 512,
    parameter int DATA_W = 17,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/grid_bin_2x2_downsample.sv =====
// Top level of the 2x2 grid binning block.
// Depends on gb2d_pkg and gb2d_line_store.
// o_valid follows the completing sample through the sum stage and the output register.
// Throughput: one sample per cycle; the input stalls only while a result is blocked.
// An accepted sample writes or reads the line store, never both; even columns do neither.
// Reset clears counters and pipeline valids; both grid sizes reset to 512, clamped.
// The line store is not cleared; it is written before read unless cols widen in an odd row.
module grid_bin_2x2_downsample #(
    parameter int MAX_COLS    = gb2d_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = gb2d_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_height_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [SAMPLE_BITS+1:0]       o_binned_height,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [gb2d_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [gb2d_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CNT_W     = $clog2(MAX_COLS);
    localparam int CE_W      = $clog2(MAX_COLS + 1);
    localparam int GC_W      = (CE_W > gb2d_pkg::COLS_W) ? CE_W : gb2d_pkg::COLS_W;
    localparam int LDEPTH    = MAX_COLS / 2;
    localparam int LA_W      = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int RW        = gb2d_pkg::ROWS_W;
    localparam int RC_W      = RW - 1;
    localparam int PAIR_W    = SAMPLE_BITS + 1;
    localparam int OUT_W     = SAMPLE_BITS + 2;

    function automatic logic [RW-1:0] clamp_rows(input logic [RW-1:0] v);
        logic [RW-1:0] res;
        res = v;
        if (v < RW'(2)) begin
            res = RW'(2);
        end else if (v > RW'(gb2d_pkg::ROWS_LIMIT)) begin
            res = RW'(gb2d_pkg::ROWS_LIMIT);
        end
        return res;
    endfunction

    function automatic logic [CE_W-1:0] clamp_cols(input logic [gb2d_pkg::COLS_W-1:0] v);
        logic [GC_W-1:0] ext;
        logic [GC_W-1:0] res;
        ext = GC_W'(v);
        res = ext;
        if (ext < GC_W'(2)) begin
            res = GC_W'(2);
        end else if (ext > GC_W'(MAX_COLS)) begin
            res = GC_W'(MAX_COLS);
        end
        return res[CE_W-1:0];
    endfunction

    localparam logic [RW-1:0]   ROWS_RST = clamp_rows(RW'(gb2d_pkg::ROWS_RESET));
    localparam logic [CE_W-1:0] COLS_RST = clamp_cols(gb2d_pkg::COLS_W'(gb2d_pkg::COLS_RESET));

    logic [RW-1:0]               r_rows_eff;
    logic [CE_W-1:0]             r_cols_eff;
    logic [RC_W-1:0]             r_row_cnt;
    logic [CNT_W-1:0]            r_col_cnt;
    logic signed [SAMPLE_BITS-1:0] r_hps;
    logic                        r_s1_valid;
    logic signed [PAIR_W-1:0]    r_s1_pair;
    logic                        r_s1_last;
    logic                        r_out_valid;
    logic signed [OUT_W-1:0]     r_out_sum;
    logic                        r_out_last;

    logic                        acc_in;
    logic                        adv;
    logic                        produce;
    logic                        is_last;
    logic                        wr_en;
    logic                        rd_en;
    logic [LA_W-1:0]             slot;
    logic signed [PAIR_W-1:0]    pair_sum;
    logic [PAIR_W-1:0]           rd_data;
    logic [CE_W-1:0]             col_inc;
    logic [RW-1:0]               row_inc;
    logic [RW-1:0]               last_row;
    logic [CE_W-1:0]             last_col;
    logic [RW-1:0]               n_rows_eff;
    logic [CE_W-1:0]             n_cols_eff;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !adv;
    assign acc_in  = i_valid && !o_stall;

    assign slot     = r_col_cnt[LA_W:1];
    assign pair_sum = PAIR_W'(r_hps) + PAIR_W'(i_height_sample);
    assign col_inc  = CE_W'(r_col_cnt) + CE_W'(1);
    assign row_inc  = RW'(r_row_cnt) + RW'(1);
    assign last_row = {r_rows_eff[RW-1:1], 1'b0} - RW'(1);
    assign last_col = {r_cols_eff[CE_W-1:1], 1'b0} - CE_W'(1);

    assign produce = r_col_cnt[0] && r_row_cnt[0]
                     && (CE_W'(r_col_cnt) < r_cols_eff)
                     && (RW'(r_row_cnt) < r_rows_eff);
    assign is_last = (RW'(r_row_cnt) == last_row) && (CE_W'(r_col_cnt) == last_col);
    assign wr_en   = acc_in && r_col_cnt[0] && !r_row_cnt[0];
    assign rd_en   = acc_in && produce;

    assign n_rows_eff = clamp_rows(i_cfg_data[RW-1:0]);
    assign n_cols_eff = clamp_cols(i_cfg_data[gb2d_pkg::COLS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_eff <= ROWS_RST;
            r_cols_eff <= COLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gb2d_pkg::REG_GRID_ROWS: r_rows_eff <= n_rows_eff;
                gb2d_pkg::REG_GRID_COLS: r_cols_eff <= n_cols_eff;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_hps     <= '0;
        end else if (acc_in) begin
            if (!r_col_cnt[0]) begin
                r_hps <= i_height_sample;
            end
            if (col_inc >= r_cols_eff) begin
                r_col_cnt <= '0;
                r_row_cnt <= (row_inc >= r_rows_eff) ? '0 : row_inc[RC_W-1:0];
            end else begin
                r_col_cnt <= col_inc[CNT_W-1:0];
            end
        end
    end

    gb2d_line_store #(
        .DEPTH  (LDEPTH),
        .DATA_W (PAIR_W),
        .ADDR_W (LA_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot),
        .i_wr_data (pair_sum),
        .i_rd_en   (rd_en),
        .i_rd_addr (slot),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_in) begin
            r_s1_valid <= produce;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_pair <= pair_sum;
            r_s1_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_sum  <= OUT_W'($signed(rd_data)) + OUT_W'(r_s1_pair);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_binned_height = r_out_sum;
    assign o_frame_last    = r_out_last;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && r_s1_valid))
        else $error("Input stalled without a blocked result.");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_stall) |=> r_s1_valid)
        else $error("Pending result dropped while the output was stalled.");

    a_rd_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_s1_valid)
        else $error("Line store read did not load the sum stage.");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv) |=> r_out_valid)
        else $error("Sum stage advanced without loading the output register.");

endmodule

// ===== verif/tb_grid_bin_2x2_downsample.sv =====
// Self-checking testbench for grid_bin_2x2_downsample: a directed table, then random phases
// with random grid sizes, input gaps and output stalls, checked by a predictor or table values.
// Depends on gb2d_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_grid_bin_2x2_downsample;

    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 100;
    localparam int PLAN_LEN      = 32;

    typedef enum logic [1:0] {STEP_SAMPLE, STEP_ROWS, STEP_COLS} t_step_kind;

    typedef struct packed {
        int height;
        bit last;
    } t_binned;

    typedef struct packed {
        bit      typed;
        t_binned want;
    } t_sample_note;

    typedef struct packed {
        t_step_kind  kind;
        logic [15:0] value;
        bit          typed;
        int          exp_h;
        bit          exp_last;
    } t_plan_step;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic signed [15:0]     i_height_sample = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic signed [17:0]     o_binned_height;
    logic                   o_frame_last;
    logic                   i_cfg_we = 1'b0;
    logic [gb2d_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [gb2d_pkg::CFG_W-1:0]     i_cfg_data = '0;

    logic [gb2d_pkg::ROWS_W-1:0] rows_cfg = gb2d_pkg::ROWS_W'(gb2d_pkg::ROWS_RESET);
    logic [gb2d_pkg::COLS_W-1:0] cols_cfg = gb2d_pkg::COLS_W'(gb2d_pkg::COLS_RESET);
    int unsigned            row_pos = 0;
    int unsigned            col_pos = 0;
    logic signed [16:0]     pair_first = '0;
    logic signed [16:0]     line_sums [gb2d_pkg::MAX_COLS_DEF/2];

    t_binned                binned_expect [$];
    t_sample_note           sample_notes [$];
    int                     n_errors = 0;
    int unsigned            cycle_count = 0;
    bit                     burst_mode = 1'b0;

    t_plan_step plan [PLAN_LEN] = '{
        '{STEP_ROWS,   16'd2,    1'b0, 0, 1'b0},
        '{STEP_COLS,   16'd2,    1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h7FFF, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h7FFF, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h7FFF, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h7FFF, 1'b1, 131068, 1'b1},
        '{STEP_SAMPLE, 16'h8000, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h8000, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h8000, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h8000, 1'b1, -131072, 1'b1},
        '{STEP_ROWS,   16'd0,    1'b0, 0, 1'b0},
        '{STEP_COLS,   16'h1801, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'd1,    1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'd2,    1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'd3,    1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'd4,    1'b1, 10, 1'b1},
        '{STEP_ROWS,   16'd3,    1'b0, 0, 1'b0},
        '{STEP_COLS,   16'd3,    1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h5555, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'hAAAA, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h0001, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'hFFFF, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h7FFF, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h8000, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h0F0F, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'hF0F0, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h0000, 1'b0, 0, 1'b0},
        '{STEP_ROWS,   16'h1FFF, 1'b0, 0, 1'b0},
        '{STEP_COLS,   16'h07FF, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h00FF, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'hFF00, 1'b0, 0, 1'b0},
        '{STEP_SAMPLE, 16'h3C3C, 1'b0, 0, 1'b0}
    };

    grid_bin_2x2_downsample u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_height_sample (i_height_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_binned_height (o_binned_height),
        .o_frame_last    (o_frame_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned rows_limit(input logic [gb2d_pkg::ROWS_W-1:0] v);
        if (v < 2) return 2;
        if (v > gb2d_pkg::ROWS_LIMIT) return gb2d_pkg::ROWS_LIMIT;
        return v;
    endfunction

    function automatic int unsigned cols_limit(input logic [gb2d_pkg::COLS_W-1:0] v);
        if (v < 2) return 2;
        if (v > gb2d_pkg::MAX_COLS_DEF) return gb2d_pkg::MAX_COLS_DEF;
        return v;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        if (r == 2) return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [gb2d_pkg::CFG_W-1:0] pick_rows();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 13'($urandom_range(2, 9));
        if (r < 78) return 13'($urandom_range(0, 1));
        if (r < 86) return 13'($urandom_range(10, 40));
        if (r < 92) return 13'(gb2d_pkg::ROWS_LIMIT);
        if (r < 96) return 13'($urandom);
        return 13'h1FFF;
    endfunction

    function automatic logic [gb2d_pkg::CFG_W-1:0] pick_cols();
        int unsigned r;
        logic [gb2d_pkg::COLS_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 70) v = 11'($urandom_range(2, 20));
        else if (r < 78) v = 11'($urandom_range(0, 1));
        else if (r < 86) v = 11'($urandom_range(21, 64));
        else if (r < 92) v = 11'(gb2d_pkg::MAX_COLS_DEF);
        else v = 11'($urandom_range(gb2d_pkg::MAX_COLS_DEF + 1, 2047));
        return {2'($urandom), v};
    endfunction

    task automatic bin_predict(input logic signed [15:0] x, output bit produced,
                               output t_binned res);
        int unsigned rows;
        int unsigned cols;
        int unsigned slot;
        logic signed [17:0] sum;
        rows = rows_limit(rows_cfg);
        cols = cols_limit(cols_cfg);
        slot = col_pos >> 1;
        produced = 1'b0;
        res = '0;
        if (!col_pos[0]) begin
            pair_first = x;
        end else if (!row_pos[0]) begin
            line_sums[slot] = pair_first + x;
        end else if (col_pos < cols && row_pos < rows) begin
            sum = line_sums[slot] + pair_first + x;
            res.height = sum;
            res.last = (row_pos == (rows & ~32'd1) - 1) && (col_pos == (cols & ~32'd1) - 1);
            produced = 1'b1;
        end
        if (col_pos + 1 >= cols) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (binned_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [gb2d_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gb2d_pkg::CFG_W-1:0] data);
        i_valid <= 1'b0;
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [15:0] value, input bit typed, input int exp_h,
                               input bit exp_last);
        int gap;
        t_sample_note note;
        gap = (burst_mode || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        note.typed = typed;
        note.want.height = exp_h;
        note.want.last = exp_last;
        sample_notes.push_back(note);
        i_valid <= 1'b1;
        i_height_sample <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Both channels and the register port are observed at each edge, in a fixed order.
    always @(posedge i_clk) begin
        t_sample_note note;
        t_binned res;
        t_binned want;
        bit produced;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_addr == gb2d_pkg::REG_GRID_ROWS)
                    rows_cfg = i_cfg_data[gb2d_pkg::ROWS_W-1:0];
                else if (i_cfg_addr == gb2d_pkg::REG_GRID_COLS)
                    cols_cfg = i_cfg_data[gb2d_pkg::COLS_W-1:0];
            end
            if (i_valid && !o_stall) begin
                note = sample_notes.pop_front();
                bin_predict(i_height_sample, produced, res);
                if (produced) binned_expect.push_back(note.typed ? note.want : res);
            end
            if (o_valid && !i_stall) begin
                if (binned_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d last %0b",
                                              o_binned_height, o_frame_last));
                end else begin
                    want = binned_expect.pop_front();
                    if (int'(o_binned_height) != want.height)
                        report_mismatch($sformatf("binned_height %0d, expected %0d",
                                                  o_binned_height, want.height));
                    if (o_frame_last != want.last)
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  o_frame_last, want.last));
                end
            end
        end
    end

    initial begin
        int stretch;
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b0;
                stretch = $urandom_range(20, 80);
            end else begin
                i_stall <= 1'b1;
                repeat (idle_len()) @(posedge i_clk);
                i_stall <= 1'b0;
                stretch = $urandom_range(1, 6);
            end
            repeat (stretch) @(posedge i_clk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int samples_sent;
        int n;
        int remaining;
        int unsigned choice;
        int unsigned rows_now;
        int unsigned cols_now;
        logic [gb2d_pkg::CFG_W-1:0] new_cols;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == STEP_SAMPLE)
                send_sample(plan[k].value, plan[k].typed, plan[k].exp_h, plan[k].exp_last);
            else if (plan[k].kind == STEP_ROWS)
                set_reg(gb2d_pkg::REG_GRID_ROWS, plan[k].value[gb2d_pkg::CFG_W-1:0]);
            else
                set_reg(gb2d_pkg::REG_GRID_COLS, plan[k].value[gb2d_pkg::CFG_W-1:0]);
        end

        samples_sent = 0;
        while (samples_sent < RANDOM_ITEMS) begin
            i_valid <= 1'b0;
            wait_idle();
            burst_mode = ($urandom_range(0, 3) == 0);
            choice = $urandom_range(0, 3);
            if (choice == 1 || choice == 3) set_reg(gb2d_pkg::REG_GRID_ROWS, pick_rows());
            if (choice == 2 || choice == 3) begin
                new_cols = pick_cols();
                // An odd row reads pair sums of the row above, so it must not widen.
                if (!(row_pos[0] && cols_limit(new_cols[gb2d_pkg::COLS_W-1:0])
                                    > cols_limit(cols_cfg)))
                    set_reg(gb2d_pkg::REG_GRID_COLS, new_cols);
            end
            rows_now = rows_limit(rows_cfg);
            cols_now = cols_limit(cols_cfg);
            if (row_pos < rows_now) remaining = (rows_now - row_pos) * cols_now - col_pos;
            else remaining = cols_now - col_pos;
            if ($urandom_range(0, 1) == 1 && remaining >= 1 && remaining <= 150) n = remaining;
            else n = $urandom_range(1, 60);
            repeat (n) send_sample(rand_sample(), 1'b0, 0, 1'b0);
            samples_sent += n;
        end

        i_valid <= 1'b0;
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
